// ----- hw/rtl/ssfe_pkg.sv -----
// Shared types and codes for the sorted store with floor extraction.
// Used by ssfe_cell and sorted_store_floor_extract; depends on nothing.
`default_nettype none

package ssfe_pkg;

   // Width of the value fields on the ports
   localparam int FIELD_BITS = 32;

   // Item command codes
   localparam logic CMD_INSERT  = 1'b0;
   localparam logic CMD_REQUEST = 1'b1;

   // Result status codes
   typedef enum logic [1:0] {
      STAT_INSERTED = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_FOUND    = 2'd2,
      STAT_NONE     = 2'd3
   } status_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_COMPARE = 2'd1,
      ST_SHIFT   = 2'd2,
      ST_GATHER  = 2'd3
   } state_type;

   // Control broadcast from the sequencer to every cell
   typedef struct packed {
      logic compare;   // latch the "not above key" flag
      logic shift;     // apply the insert or delete shift
      logic insert;    // shift direction: 1 opens a slot, 0 closes one
   } ctrl_type;

endpackage

`default_nettype wire

// ----- hw/rtl/ssfe_cell.sv -----
// One cell of the sorted chain: holds one value and its compare flag.
// Depends on ssfe_pkg; instanced in a row by sorted_store_floor_extract.
`default_nettype none

module ssfe_cell
   import ssfe_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire ctrl_type              ctrl,
   input  wire logic [VALUE_BITS-1:0] key,
   input  wire logic                  valid,
   input  wire logic [VALUE_BITS-1:0] left_value,
   input  wire logic                  left_le,
   input  wire logic [VALUE_BITS-1:0] right_value,
   input  wire logic                  right_le,
   output logic      [VALUE_BITS-1:0] value,
   output logic                       le,
   output logic      [VALUE_BITS-1:0] pick
);

   logic [VALUE_BITS-1:0] value_ff;
   logic [VALUE_BITS-1:0] value_in;
   logic                  le_ff;
   logic                  le_in;
   logic                  selected;

   // Flag: this entry is held and not above the key (a prefix of the row)
   always_comb begin
      le_in = le_ff;
      if (ctrl.compare) begin
         le_in = valid && (value_ff <= key);
      end
   end

   // Last cell of the prefix holds the floor value
   assign selected = le_ff && !right_le;

   // Insert: cells past the prefix move right, the first one takes the key.
   // Delete: the floor cell and all after it take their right neighbour.
   always_comb begin
      value_in = value_ff;
      if (ctrl.shift) begin
         if (ctrl.insert) begin
            if (!le_ff) begin
               value_in = left_le ? key : left_value;
            end
         end else begin
            if (!right_le) begin
               value_in = right_value;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      le_ff    <= le_in;
   end

   assign value = value_ff;
   assign le    = le_ff;
   assign pick  = selected ? value_ff : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_store_floor_extract.sv -----
// Sorted multiset store with floor search and delete, top level.
// An accepted item runs the compare, shift and gather steps, then the registered result strobe rises.
// A new item is taken only when busy is low, once the compare/shift/gather sequence of the cell row ends.
// The receiver cannot stall: each result shows for one cycle while busy is already low.
// Reset clears the sequencer and the fill count; cell contents are left undefined.
// Depends on ssfe_pkg and ssfe_cell.
`default_nettype none

module sorted_store_floor_extract
   import ssfe_pkg::*;
#(
   parameter int CAPACITY   = 256,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_cmd,
   input  wire logic [FIELD_BITS-1:0] req_value,
   output logic                       rsp_strobe,
   output logic      [1:0]            rsp_status,
   output logic      [FIELD_BITS-1:0] rsp_found_value
);

   localparam int CNT_BITS   = $clog2(CAPACITY + 1);
   localparam int GROUP      = 16;
   localparam int NUM_GROUPS = (CAPACITY + GROUP - 1) / GROUP;
   localparam int PADDED     = NUM_GROUPS * GROUP;

   state_type             state_ff;
   state_type             state_in;
   logic                  cmd_ff;
   logic [VALUE_BITS-1:0] key_ff;
   logic [VALUE_BITS-1:0] key_in;
   logic [CNT_BITS-1:0]   count_ff;
   logic [CNT_BITS-1:0]   count_in;
   status_type            status_ff;
   status_type            status_in;
   logic [VALUE_BITS-1:0] group_ff [NUM_GROUPS];
   logic [VALUE_BITS-1:0] group_in [NUM_GROUPS];
   logic [VALUE_BITS-1:0] floor_wide;
   logic                  rsp_strobe_ff;
   status_type            rsp_status_ff;
   logic [FIELD_BITS-1:0] rsp_found_ff;
   logic [FIELD_BITS-1:0] found_in;
   ctrl_type              ctrl;
   logic                  accept;
   logic                  full;
   logic                  any_le;

   logic [VALUE_BITS-1:0] cell_value [CAPACITY];
   logic                  cell_le    [CAPACITY];
   logic                  cell_valid [CAPACITY];
   logic [VALUE_BITS-1:0] left_value [CAPACITY];
   logic                  left_le    [CAPACITY];
   logic [VALUE_BITS-1:0] right_value[CAPACITY];
   logic                  right_le   [CAPACITY];
   logic [VALUE_BITS-1:0] cell_pick  [PADDED];

   assign accept = start && !busy;
   assign full   = (count_ff == CNT_BITS'(CAPACITY));
   assign any_le = cell_le[0];

   // Input value to the store width
   generate
      if (VALUE_BITS >= FIELD_BITS) begin : g_key_ext
         assign key_in = VALUE_BITS'(req_value);
      end else begin : g_key_trunc
         assign key_in = req_value[VALUE_BITS-1:0];
      end
   endgenerate

   // Row of cells with their neighbour links
   generate
      for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
         assign cell_valid[i] = (CNT_BITS'(i) < count_ff);

         if (i == 0) begin : g_left_end
            assign left_value[i] = key_ff;
            assign left_le[i]    = 1'b1;
         end else begin : g_left
            assign left_value[i] = cell_value[i-1];
            assign left_le[i]    = cell_le[i-1];
         end

         if (i == CAPACITY - 1) begin : g_right_end
            assign right_value[i] = cell_value[i];
            assign right_le[i]    = 1'b0;
         end else begin : g_right
            assign right_value[i] = cell_value[i+1];
            assign right_le[i]    = cell_le[i+1];
         end

         ssfe_cell #(
            .VALUE_BITS(VALUE_BITS)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .key        (key_ff),
            .valid      (cell_valid[i]),
            .left_value (left_value[i]),
            .left_le    (left_le[i]),
            .right_value(right_value[i]),
            .right_le   (right_le[i]),
            .value      (cell_value[i]),
            .le         (cell_le[i]),
            .pick       (cell_pick[i])
         );
      end

      for (genvar p = CAPACITY; p < PADDED; p++) begin : g_pad
         assign cell_pick[p] = '0;
      end
   endgenerate

   // First tree level: OR the picks of each group of cells
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int j = 0; j < GROUP; j++) begin
            group_in[g] = group_in[g] | cell_pick[g*GROUP + j];
         end
      end
   end

   // Second tree level: OR the registered groups
   always_comb begin
      floor_wide = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         floor_wide = floor_wide | group_ff[g];
      end
   end

   generate
      if (VALUE_BITS >= FIELD_BITS) begin : g_out_trunc
         assign found_in = (status_ff == STAT_FOUND) ? floor_wide[FIELD_BITS-1:0] : '0;
      end else begin : g_out_ext
         assign found_in = (status_ff == STAT_FOUND) ? FIELD_BITS'(floor_wide) : '0;
      end
   endgenerate

   // Sequencer: next state, cell control, count and status
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      status_in   = status_ff;
      ctrl.compare = 1'b0;
      ctrl.shift   = 1'b0;
      ctrl.insert  = (cmd_ff == CMD_INSERT);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            ctrl.compare = 1'b1;
            state_in     = ST_SHIFT;
         end
         ST_SHIFT: begin
            state_in = ST_GATHER;
            if (cmd_ff == CMD_INSERT) begin
               if (full) begin
                  status_in = STAT_FULL;
               end else begin
                  status_in  = STAT_INSERTED;
                  ctrl.shift = 1'b1;
                  count_in   = count_ff + CNT_BITS'(1);
               end
            end else begin
               if (any_le) begin
                  status_in  = STAT_FOUND;
                  ctrl.shift = 1'b1;
                  count_in   = count_ff - CNT_BITS'(1);
               end else begin
                  status_in = STAT_NONE;
               end
            end
         end
         ST_GATHER: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= (state_ff == ST_GATHER);
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd;
         key_ff <= key_in;
      end
      status_ff <= status_in;
      if (state_ff == ST_SHIFT) begin
         group_ff <= group_in;
      end
      if (state_ff == ST_GATHER) begin
         rsp_status_ff <= status_ff;
         rsp_found_ff  <= found_in;
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_found_ff;

   // Checks
   a_strobe_after_gather: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_GATHER))
      else $error("result strobe without gather step");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_COMPARE)
      else $error("accepted item did not start a compare");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(CAPACITY))
      else $error("fill count beyond capacity");

   a_zero_when_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status_ff != STAT_FOUND |-> rsp_found_value == '0)
      else $error("found value not zero on a miss or insert");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_SHIFT |=> $stable(count_ff))
      else $error("fill count changed outside the shift step");

endmodule

`default_nettype wire
